>>> rtl/hvd_pkg.sv
// haversine distance package: fixed-point formats, cordic and root constants
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package hvd_pkg;

  localparam int CordicStepsDef = 24;

  // angles are q30 radians, trig values q30
  localparam int AngW      = 34;
  localparam int TrigW     = 32;
  localparam int SqrtSteps = 31;
  localparam int SqrtW     = 62;

  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259424;
  localparam logic signed [AngW-1:0] TwoPiQ30  = 34'sd6746518848;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629712;
  localparam logic signed [AngW-1:0] GainQ30   = 34'sd652032874;
  localparam logic [30:0]            OneQ30    = 31'h40000000;

  localparam logic signed [AngW-1:0] AtanTab [32] = '{
    34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
    34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
    34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
    34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
    34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
    34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F,
    34'sh00000003F, 34'sh00000001F, 34'sh00000000F, 34'sh000000008,
    34'sh000000004, 34'sh000000002, 34'sh000000001, 34'sh000000000
  };

  // degrees to radians: |d| = 45*q + r, q by reciprocal, r*pi/4/45 by table
  localparam int                DegDen       = 45;
  localparam logic [25:0]       DegRecip     = 26'd47721859;
  localparam int                DegShift     = 31;
  localparam int                DegFrac      = 16;
  localparam logic [29:0]       QuarterPiQ30 = 30'd843314856;

  typedef logic [29:0] rem_tab_t [DegDen];

  function automatic rem_tab_t build_rem_tab();
    rem_tab_t tab;
    for (int r = 0; r < DegDen; r++) begin
      tab[r] = 30'((64'(r) * 64'(QuarterPiQ30)) / DegDen);
    end
    return tab;
  endfunction

  localparam rem_tab_t RemTab = build_rem_tab();

  localparam logic [22:0] EarthRadiusM = 23'd6371000;
  localparam logic [24:0] DistMax      = 25'h1FFFFFF;

endpackage

>>> rtl/hvd_cordic.sv
// pipelined cordic rotation: sine and cosine of a q30 angle, one iteration per stage
// depends on hvd_pkg
`timescale 1ns / 1ps
module hvd_cordic #(
  parameter int Steps = hvd_pkg::CordicStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [hvd_pkg::AngW-1:0]   ang_i,
  output logic                              valid_o,
  output logic signed [hvd_pkg::TrigW-1:0]  sin_o,
  output logic signed [hvd_pkg::TrigW-1:0]  cos_o
);
  import hvd_pkg::*;

  logic signed [AngW-1:0] wrap_d, z0_d;
  logic                   neg_d;

  logic signed [AngW-1:0] x_q [Steps+1];
  logic signed [AngW-1:0] y_q [Steps+1];
  logic signed [AngW-1:0] z_q [Steps+1];
  logic                   neg_q [Steps+1];
  logic [Steps:0]         vld_q;
  logic                   out_vld_q;
  logic signed [TrigW-1:0] sin_q, cos_q;

  // wrap to [-pi, pi], then fold to [-pi/2, pi/2]
  always_comb begin
    wrap_d = ang_i;
    if (ang_i > PiQ30) begin
      wrap_d = ang_i - TwoPiQ30;
    end else if (ang_i < -PiQ30) begin
      wrap_d = ang_i + TwoPiQ30;
    end
    z0_d  = wrap_d;
    neg_d = 1'b0;
    if (wrap_d > HalfPiQ30) begin
      z0_d  = wrap_d - PiQ30;
      neg_d = 1'b1;
    end else if (wrap_d < -HalfPiQ30) begin
      z0_d  = wrap_d + PiQ30;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[Steps-1:0], valid_i};
      out_vld_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= GainQ30;
    y_q[0]   <= '0;
    z_q[0]   <= z0_d;
    neg_q[0] <= neg_d;
    for (int i = 0; i < Steps; i++) begin
      neg_q[i+1] <= neg_q[i];
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - AtanTab[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + AtanTab[i];
      end
    end
    sin_q <= TrigW'(neg_q[Steps] ? -y_q[Steps] : y_q[Steps]);
    cos_q <= TrigW'(neg_q[Steps] ? -x_q[Steps] : x_q[Steps]);
  end

  assign valid_o = out_vld_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

>>> rtl/hvd_isqrt.sv
// pipelined restoring square root of a q30 value scaled by 2^30, one result bit per stage
// depends on hvd_pkg
`timescale 1ns / 1ps
module hvd_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [30:0] val_i,
  output logic        valid_o,
  output logic [30:0] root_o
);
  import hvd_pkg::*;

  logic [SqrtW-1:0] v_q    [SqrtSteps+1];
  logic [SqrtW-1:0] root_q [SqrtSteps+1];
  logic [SqrtSteps:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SqrtSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    v_q[0]    <= {1'b0, val_i, 30'd0};
    root_q[0] <= '0;
    for (int k = 0; k < SqrtSteps; k++) begin
      if (v_q[k] >= root_q[k] + (SqrtW'(1) << (2 * (SqrtSteps - 1 - k)))) begin
        v_q[k+1]    <= v_q[k] - (root_q[k] + (SqrtW'(1) << (2 * (SqrtSteps - 1 - k))));
        root_q[k+1] <= (root_q[k] >> 1) + (SqrtW'(1) << (2 * (SqrtSteps - 1 - k)));
      end else begin
        v_q[k+1]    <= v_q[k];
        root_q[k+1] <= root_q[k] >> 1;
      end
    end
  end

  assign valid_o = vld_q[SqrtSteps];
  assign root_o  = root_q[SqrtSteps][30:0];

endmodule

>>> rtl/haversine_distance_top.sv
// haversine great-circle distance, fully pipelined top level
// depends on hvd_pkg, hvd_cordic, hvd_isqrt
`timescale 1ns / 1ps
// Takes two points (latitude, longitude in degrees times 2^16) and returns
// the great-circle distance on a 6371 km sphere in whole metres, rounded.
// A word is taken at every clock edge where start is high; busy stays low,
// so one word per cycle is sustained. The distance appears on distance_m_o
// for exactly one cycle with done_o high. The result passes through the
// rotation cordic (sin/cos), the 31-stage square-root pipeline and the
// vectoring cordic (atan2), each unrolled to one iteration per register
// stage. Results come out in input order and cannot be held off: the
// receiver must take every done_o cycle.
module haversine_distance_top #(
  parameter int CORDIC_STEPS = hvd_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] lat_a_i,
  input  logic signed [24:0] lon_a_i,
  input  logic signed [23:0] lat_b_i,
  input  logic signed [24:0] lon_b_i,
  output logic               done_o,
  output logic [24:0]        distance_m_o
);
  import hvd_pkg::*;

  localparam int Lat = 2 * CORDIC_STEPS + 46;

  // ---------------- degrees to q30 radians (4 lanes) ----------------
  // lanes: first latitude, second latitude, half latitude delta, half longitude delta
  logic signed [25:0] ang_d [4];
  logic [24:0]        mag_d [4];
  logic [50:0]        sum_d [4];
  logic [AngW-1:0]    rmag_d [4];

  logic [24:0] m0_q [4];
  logic [24:0] m1_q [4];
  logic [19:0] q0_q [4];
  logic [5:0]  r_q  [4];
  logic [49:0] pk_q [4];
  logic [3:0]  s0_q, s1_q, s2_q;
  logic signed [AngW-1:0] rad_q [4];
  logic [3:0]  vd_q;

  assign ang_d[0] = 26'(lat_a_i);
  assign ang_d[1] = 26'(lat_b_i);
  assign ang_d[2] = 26'(lat_b_i) - 26'(lat_a_i);
  assign ang_d[3] = 26'(lon_b_i) - 26'(lon_a_i);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_d[i] = ang_d[i][25] ? 25'(-ang_d[i]) : 25'(ang_d[i]);
      // rounding half of the divisor folds to 2^15 (full) or 2^16 (half) after the /45 step
      sum_d[i] = 51'(pk_q[i]) + ((i < 2) ? 51'(32768) : 51'(65536)) + 51'(RemTab[r_q[i]]);
      // half angles divide by 90*2^16: one more bit of shift
      rmag_d[i] = (i < 2) ? AngW'(sum_d[i] >> DegFrac) : AngW'(sum_d[i] >> (DegFrac + 1));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      m0_q[i] <= mag_d[i];
      s0_q[i] <= ang_d[i][25];
      // quotient by 45 through a reciprocal, exact for 25-bit magnitudes
      q0_q[i] <= 20'((51'(m0_q[i]) * 51'(DegRecip)) >> DegShift);
      m1_q[i] <= m0_q[i];
      s1_q[i] <= s0_q[i];
      r_q[i]  <= 6'(m1_q[i] - 25'(25'(q0_q[i]) * 25'(DegDen)));
      pk_q[i] <= 50'(q0_q[i]) * 50'(QuarterPiQ30);
      s2_q[i] <= s1_q[i];
      rad_q[i] <= s2_q[i] ? -$signed(rmag_d[i]) : $signed(rmag_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else begin
      vd_q <= {vd_q[2:0], start};
    end
  end

  // ---------------- sine / cosine ----------------
  logic                    trig_vld;
  logic signed [TrigW-1:0] cos_a, cos_b, sin_h, sin_o;

  hvd_cordic #(.Steps(CORDIC_STEPS)) u_cordic_lat_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vd_q[3]), .ang_i(rad_q[0]),
    .valid_o(trig_vld), .sin_o(), .cos_o(cos_a)
  );
  hvd_cordic #(.Steps(CORDIC_STEPS)) u_cordic_lat_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vd_q[3]), .ang_i(rad_q[1]),
    .valid_o(), .sin_o(), .cos_o(cos_b)
  );
  hvd_cordic #(.Steps(CORDIC_STEPS)) u_cordic_dlat (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vd_q[3]), .ang_i(rad_q[2]),
    .valid_o(), .sin_o(sin_h), .cos_o()
  );
  hvd_cordic #(.Steps(CORDIC_STEPS)) u_cordic_dlon (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vd_q[3]), .ang_i(rad_q[3]),
    .valid_o(), .sin_o(sin_o), .cos_o()
  );

  // ---------------- haversine term a, one product per stage ----------------
  logic signed [63:0] sq_d, cc_d, p_d, t2_d;
  logic signed [34:0] a_d;
  logic signed [33:0] t1_q, t1b_q, t1c_q, t2_q;
  logic signed [TrigW-1:0] cc_q, p_q, so1_q, so2_q;
  logic [30:0] a_q;
  logic [3:0]  vm_q;

  assign sq_d = 64'(sin_h) * 64'(sin_h);
  assign cc_d = 64'(cos_a) * 64'(cos_b);
  assign p_d  = 64'(cc_q) * 64'(so1_q);
  assign t2_d = 64'(p_q) * 64'(so2_q);
  assign a_d  = 35'(t1c_q) + 35'(t2_q);

  always_ff @(posedge clk_i) begin
    t1_q  <= 34'(sq_d >>> 30);
    cc_q  <= TrigW'(cc_d >>> 30);
    so1_q <= sin_o;
    p_q   <= TrigW'(p_d >>> 30);
    t1b_q <= t1_q;
    so2_q <= so1_q;
    t2_q  <= 34'(t2_d >>> 30);
    t1c_q <= t1b_q;
    // clamp a into 0..1 against rounding
    if (a_d < 0) begin
      a_q <= '0;
    end else if (a_d > $signed(35'(OneQ30))) begin
      a_q <= OneQ30;
    end else begin
      a_q <= a_d[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= '0;
    end else begin
      vm_q <= {vm_q[2:0], trig_vld};
    end
  end

  // ---------------- square roots of a and 1-a ----------------
  logic        sq_vld;
  logic [30:0] ra, rb;

  hvd_isqrt u_isqrt_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vm_q[3]), .val_i(a_q),
    .valid_o(sq_vld), .root_o(ra)
  );
  hvd_isqrt u_isqrt_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(vm_q[3]), .val_i(OneQ30 - a_q),
    .valid_o(), .root_o(rb)
  );

  // ---------------- atan2 by vectoring cordic ----------------
  logic signed [AngW-1:0] vx_q [CORDIC_STEPS+1];
  logic signed [AngW-1:0] vy_q [CORDIC_STEPS+1];
  logic signed [AngW-1:0] vz_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]  vv_q;

  always_ff @(posedge clk_i) begin
    vx_q[0] <= AngW'(rb);
    vy_q[0] <= AngW'(ra);
    vz_q[0] <= '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (vy_q[i] > 0) begin
        vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] + AtanTab[i];
      end else begin
        vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] - AtanTab[i];
      end
    end
  end

  // ---------------- central angle to metres ----------------
  logic [31:0] c_q;
  logic [54:0] dist_prod_q;
  logic [25:0] dist_rnd_d;
  logic [24:0] dist_q;
  logic [2:0]  vc_q;

  assign dist_rnd_d = 26'((dist_prod_q + 55'(1 << 29)) >> 30);

  always_ff @(posedge clk_i) begin
    // central angle is twice the vectoring result, never below zero
    c_q         <= vz_q[CORDIC_STEPS][AngW-1] ? 32'd0 : 32'(vz_q[CORDIC_STEPS] <<< 1);
    dist_prod_q <= 55'(c_q) * 55'(EarthRadiusM);
    dist_q      <= (dist_rnd_d > 26'(DistMax)) ? DistMax : dist_rnd_d[24:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vv_q <= '0;
      vc_q <= '0;
    end else begin
      vv_q <= {vv_q[CORDIC_STEPS-1:0], sq_vld};
      vc_q <= {vc_q[1:0], vv_q[CORDIC_STEPS]};
    end
  end

  assign busy         = 1'b0;
  assign done_o       = vc_q[2];
  assign distance_m_o = dist_q;

  // ---------------- checks ----------------
  // every result traces back to a word taken with start high, at the depth given by Lat
  a_done_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Lat))
    else $error("result without matching input word");

  // clamped haversine term stays within one
  a_a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vm_q[3] |-> (a_q <= OneQ30))
    else $error("haversine term above one");

  // sqrt(a) + sqrt(1-a) lies between 1 and sqrt(2), less floor losses
  a_root_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> ((33'(ra) + 33'(rb) >= 33'(OneQ30) - 33'd2) &&
                (33'(ra) + 33'(rb) <= 33'd1518500250)))
    else $error("square root pair out of range");

endmodule

>>> verif/haversine_distance_top_tb.sv
// testbench for haversine_distance_top: random and directed point pairs
// depends on hvd_pkg and the rtl of the block; self-checking, no files read
`timescale 1ns / 1ps
module haversine_distance_top_tb;

  localparam int Steps      = hvd_pkg::CordicStepsDef;
  localparam int Latency    = 2 * Steps + 46;
  localparam int IdleLimit  = 20 * Latency + 2000;
  localparam int NumRandom  = 630;
  localparam longint QuarterPi = 843314856;
  localparam longint PiQ       = 4 * QuarterPi;
  localparam longint HalfPiQ   = 2 * QuarterPi;
  localparam longint OneQ      = 64'd1 << 30;

  typedef struct packed {
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
  } point_pair_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [23:0] lat_a_i;
  logic signed [24:0] lon_a_i;
  logic signed [23:0] lat_b_i;
  logic signed [24:0] lon_b_i;
  logic               done_o;
  logic [24:0]        distance_m_o;

  haversine_distance_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .lat_a_i      (lat_a_i),
    .lon_a_i      (lon_a_i),
    .lat_b_i      (lat_b_i),
    .lon_b_i      (lon_b_i),
    .done_o       (done_o),
    .distance_m_o (distance_m_o)
  );

  // arctangent table, truncated q30
  longint atan_lut [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  point_pair_t   pending_pairs [$];
  logic [24:0]   expected_dist [$];
  int            sender_idle_pct;
  bit            failed = 1'b0;
  int            quiet_cycles = 0;

  // degrees*2^16 to q30 radians, rounded on the magnitude
  function automatic longint deg_to_q30(longint d, longint den);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = (mag * QuarterPi + den / 2) / den;
    return (d < 0) ? -q : q;
  endfunction

  // rotation cordic with wrap and half-turn fold; returns sine only
  function automatic longint cordic_sine(longint r);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    bit     neg;
    x = 652032874;
    y = 0;
    neg = 0;
    while (r > PiQ) r -= 2 * PiQ;
    while (r < -PiQ) r += 2 * PiQ;
    if (r > HalfPiQ) begin
      r -= PiQ;
      neg = 1;
    end else if (r < -HalfPiQ) begin
      r += PiQ;
      neg = 1;
    end
    z = r;
    for (int i = 0; i < Steps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_lut[i];
      end else begin
        x += ys; y -= xs; z += atan_lut[i];
      end
    end
    return neg ? -y : y;
  endfunction

  function automatic longint cordic_cosine(longint r);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    bit     neg;
    x = 652032874;
    y = 0;
    neg = 0;
    while (r > PiQ) r -= 2 * PiQ;
    while (r < -PiQ) r += 2 * PiQ;
    if (r > HalfPiQ) begin
      r -= PiQ;
      neg = 1;
    end else if (r < -HalfPiQ) begin
      r += PiQ;
      neg = 1;
    end
    z = r;
    for (int i = 0; i < Steps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_lut[i];
      end else begin
        x += ys; y -= xs; z += atan_lut[i];
      end
    end
    return neg ? -x : x;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    for (int i = 0; i < Steps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_lut[i];
      end else begin
        x -= ys; y += xs; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic longint int_root(longint v);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // expected distance in metres for one point pair
  function automatic logic [24:0] great_circle_m(point_pair_t p);
    longint la, oa, lb, ob;
    longint c1, c2, sh, so, t1, cc, t2, hav, ra, rb, ang, dist_m;
    la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
    c1 = cordic_cosine(deg_to_q30(la, 45 * 65536));
    c2 = cordic_cosine(deg_to_q30(lb, 45 * 65536));
    sh = cordic_sine(deg_to_q30(lb - la, 90 * 65536));
    so = cordic_sine(deg_to_q30(ob - oa, 90 * 65536));
    t1 = (sh * sh) >>> 30;
    cc = (c1 * c2) >>> 30;
    t2 = (((cc * so) >>> 30) * so) >>> 30;
    hav = t1 + t2;
    // rounding guard on the haversine term
    if (hav < 0) hav = 0;
    if (hav > OneQ) hav = OneQ;
    ra = int_root(hav << 30);
    rb = int_root((OneQ - hav) << 30);
    ang = 2 * cordic_atan2(ra, rb);
    if (ang < 0) ang = 0;
    dist_m = (6371000 * ang + (64'd1 << 29)) >>> 30;
    if (dist_m > 64'h1FFFFFF) dist_m = 64'h1FFFFFF;
    return dist_m[24:0];
  endfunction

  function automatic point_pair_t make_pair(longint la, longint oa, longint lb, longint ob);
    point_pair_t p;
    p.lat_a = la[23:0]; p.lon_a = oa[24:0];
    p.lat_b = lb[23:0]; p.lon_b = ob[24:0];
    return p;
  endfunction

  // append one pair to the pending queue
  function void add_pair(point_pair_t p);
    pending_pairs = {pending_pairs, p};
  endfunction

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: takes a word off the queue when it presents one, and logs its expectation once it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      lat_a_i <= '0;
      lon_a_i <= '0;
      lat_b_i <= '0;
      lon_b_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_dist = {expected_dist,
                         great_circle_m(make_pair(lat_a_i, lon_a_i, lat_b_i, lon_b_i))};
      end
      // present the next word unless the current one is still held
      if (!(start && busy)) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          point_pair_t p;
          p = pending_pairs.pop_front();
          start   <= 1'b1;
          lat_a_i <= p.lat_a;
          lon_a_i <= p.lon_a;
          lat_b_i <= p.lat_b;
          lon_b_i <= p.lon_b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done cycle must match the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_dist.size() == 0) begin
        $display("%0t: unexpected distance, expected none, actual %0d", $time, distance_m_o);
        failed <= 1'b1;
      end else begin
        logic [24:0] want;
        want = expected_dist.pop_front();
        if (want !== distance_m_o) begin
          $display("%0t: distance_m mismatch, expected %0d, actual %0d",
                   $time, want, distance_m_o);
          failed <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no word accepted and no result returned
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    sender_idle_pct = 16;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero distance, poles, antipodes, field extremes, wrap cases
    add_pair(make_pair(0, 0, 0, 0));
    add_pair(make_pair(5898240, 0, -5898240, 0));
    add_pair(make_pair(0, 0, 0, 11796480));
    add_pair(make_pair(0, -11796480, 0, 11796480));
    add_pair(make_pair(0, 11796480, 0, -11796480));
    add_pair(make_pair(5898240, -11796480, 5898240, 11796480));
    add_pair(make_pair(-5898240, 0, -5898240, 0));
    add_pair(make_pair(1, 0, 0, 1));
    add_pair(make_pair(0, 0, 0, 11796479));
    // raw extremes beyond the stated ranges exercise the angle wrap
    add_pair(make_pair(-8388608, -16777216, 8388607, 16777215));
    add_pair(make_pair(8388607, 16777215, -8388608, -16777216));
    add_pair(make_pair(-1, -1, -1, -1));
    add_pair(make_pair(8388607, 0, 8388607, 16777215));
    add_pair(make_pair(2949120, 5898240, -2949120, -5898240));
    add_pair(make_pair(3342336, -491520, 3342337, -491519));
    add_pair(make_pair(0, 0, 1, 0));
    add_pair(make_pair(-5898240, 11796480, 5898240, -11796480));

    for (int n = 0; n < NumRandom; n++) begin
      int kind;
      kind = $urandom_range(9);
      if (kind < 6) begin
        add_pair(make_pair(rand_span(5898240), rand_span(11796480),
                           rand_span(5898240), rand_span(11796480)));
      end else if (kind < 8) begin
        // nearby points: small differences stress the rounding guard
        longint la, oa;
        la = rand_span(5898240); oa = rand_span(11796480);
        add_pair(make_pair(la, oa, la + rand_span(200), oa + rand_span(200)));
      end else begin
        // raw bit patterns, out of range included
        add_pair(make_pair($urandom, $urandom, $urandom, $urandom));
      end
      if (n == NumRandom / 3) begin
        wait (pending_pairs.size() == 0);
        sender_idle_pct = 53;
      end else if (n == 2 * NumRandom / 3) begin
        wait (pending_pairs.size() == 0);
        sender_idle_pct = 0;
      end
    end

    wait (pending_pairs.size() == 0);
    @(posedge clk_i);
    wait (!start && expected_dist.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (!failed && expected_dist.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/hvd_pkg.sv
rtl/hvd_cordic.sv
rtl/hvd_isqrt.sv
rtl/haversine_distance_top.sv
verif/haversine_distance_top_tb.sv
